/* rtl/spsq_pkg.sv */
// shared types, codes and defaults for the strict priority stream queues
package spsq_pkg;

  // default sizing
  localparam int NumStreamsDef = 16;
  localparam int NumLevelsDef  = 4;
  localparam int QueueDepthDef = 16;

  // reset values
  localparam logic [7:0] WindowReset    = 8'd64;
  localparam logic [7:0] MaxWindowReset = 8'd64;

  // command codes
  localparam logic [1:0] CMD_SUBMIT = 2'd0;
  localparam logic [1:0] CMD_SERVE  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  // input transaction
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  stream;
    logic [1:0]  priority_req;
    logic [15:0] handle;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] served_handle;
    logic [1:0]  served_priority;
    logic [7:0]  window;
    logic [31:0] processed;
  } out_item_t;

endpackage

/* rtl/strict_priority_stream_queues_top.sv */
// top level of the strict priority stream queues
//
// Each stream owns one ring fifo of 16-bit handles per priority level.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries submit, serve
// and tick commands; output channel (out_valid_o/out_ready_i, out_data_o)
// returns exactly one result transaction per command.
// Configuration: cfg_we_i writes cfg_wdata_i into max_window at once.
// The state row read at the accept edge arrives in ST_EXEC, which updates
// it, writes it back and, for a serve, reads the handle memory; ST_RESP
// loads the result into the output register. While the receiver keeps up,
// the next command may be accepted as ST_RESP loads that result.
// The block works on one command at a time.
// When the receiver stalls, the finished result waits in the output
// register; one more command may be accepted, and it then waits with its
// result ready until that register frees.
// Reset: all fifos empty, windows 64, counters and the seconds count zero,
// max_window 64; no clearing pass, rows not yet written read as reset.
module strict_priority_stream_queues_top #(
  parameter int NUM_STREAMS = spsq_pkg::NumStreamsDef,
  parameter int NUM_LEVELS  = spsq_pkg::NumLevelsDef,
  parameter int QUEUE_DEPTH = spsq_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  spsq_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output spsq_pkg::out_item_t out_data_o
);

  localparam int SW  = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int LW  = $clog2(NUM_LEVELS);
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LVW = 2 * PW + CW;
  localparam int LB  = NUM_LEVELS * LVW;
  localparam int RW  = LB + 72;
  localparam int HAW = SW + LW + PW;
  localparam logic [RW-1:0] ROW_RESET = {32'd0, 32'd0, spsq_pkg::WindowReset, LB'(0)};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  served_priority;
    logic [7:0]  window;
    logic [31:0] processed;
    logic        hit;
  } res_t;

  state_e              state_q;
  spsq_pkg::in_item_t  cur_q;
  res_t                res_q, res_d;
  spsq_pkg::out_item_t out_q;
  logic                out_valid_q;
  logic [7:0]          max_window_q;
  logic [31:0]         seconds_q;

  logic in_fire, out_free, in_stream_ok;

  logic [RW-1:0] row_rd, row_wr;
  logic          row_we;
  logic [SW-1:0] sidx;
  logic          svalid;

  logic [PW-1:0] wp [NUM_LEVELS];
  logic [PW-1:0] rp [NUM_LEVELS];
  logic [CW-1:0] cnt [NUM_LEVELS];
  logic [PW-1:0] wp_n [NUM_LEVELS];
  logic [PW-1:0] rp_n [NUM_LEVELS];
  logic [CW-1:0] cnt_n [NUM_LEVELS];
  logic [7:0]    win, win_n;
  logic [31:0]   last, last_n, served, served_n;

  logic          lvl_ok, sub_ok, srv_hit;
  logic [LW-1:0] sub_lvl, sel_lvl;
  logic [31:0]   elapsed;
  logic [8:0]    w9, top9;
  logic [15:0]   hm_rdata;

  // handshake
  assign out_free     = !out_valid_q || out_ready_i;
  assign in_ready_o   = (state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free);
  assign in_fire      = in_valid_i && in_ready_o;
  assign in_stream_ok = int'(in_data_i.stream) < NUM_STREAMS;
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;

  // current transaction decode
  assign sidx    = SW'(cur_q.stream);
  assign svalid  = int'(cur_q.stream) < NUM_STREAMS;
  assign lvl_ok  = int'(cur_q.priority_req) < NUM_LEVELS;
  assign sub_lvl = LW'(cur_q.priority_req);

  // unpack the state row
  always_comb begin
    for (int k = 0; k < NUM_LEVELS; k++) begin
      wp[k]  = row_rd[k*LVW +: PW];
      rp[k]  = row_rd[k*LVW + PW +: PW];
      cnt[k] = row_rd[k*LVW + 2*PW +: CW];
    end
    win    = row_rd[LB +: 8];
    last   = row_rd[LB + 8 +: 32];
    served = row_rd[LB + 40 +: 32];
  end

  // highest non-empty level
  always_comb begin
    srv_hit = 1'b0;
    sel_lvl = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (cnt[k] != '0) begin
        srv_hit = 1'b1;
        sel_lvl = LW'(k);
      end
    end
  end

  assign sub_ok = svalid && lvl_ok && (cnt[sub_lvl] < CW'(QUEUE_DEPTH));

  // window adjustment for a pop
  always_comb begin
    elapsed = seconds_q - last;
    top9    = (max_window_q == 8'd0) ? 9'd1 : {1'b0, max_window_q};
    w9      = {1'b0, win} + ((elapsed > 32'd1) ? 9'd1 : 9'd0);
    if (w9 > top9) begin
      w9 = top9;
    end else if (w9 == 9'd0) begin
      w9 = 9'd1;
    end
  end

  // next row and result
  always_comb begin
    for (int k = 0; k < NUM_LEVELS; k++) begin
      wp_n[k]  = wp[k];
      rp_n[k]  = rp[k];
      cnt_n[k] = cnt[k];
    end
    win_n    = win;
    last_n   = last;
    served_n = served;
    row_we   = 1'b0;
    res_d    = '0;
    case (cur_q.cmd)
      spsq_pkg::CMD_SUBMIT: begin
        res_d.status = spsq_pkg::STATUS_FULL;
        if (sub_ok) begin
          res_d.status  = spsq_pkg::STATUS_OK;
          wp_n[sub_lvl] = (wp[sub_lvl] == PW'(QUEUE_DEPTH - 1)) ? '0 : wp[sub_lvl] + 1'b1;
          cnt_n[sub_lvl] = cnt[sub_lvl] + 1'b1;
          row_we = 1'b1;
        end
      end
      spsq_pkg::CMD_SERVE: begin
        res_d.status = spsq_pkg::STATUS_EMPTY;
        if (svalid && srv_hit) begin
          res_d.status          = spsq_pkg::STATUS_OK;
          res_d.served_priority = 2'(sel_lvl);
          res_d.hit             = 1'b1;
          rp_n[sel_lvl]  = (rp[sel_lvl] == PW'(QUEUE_DEPTH - 1)) ? '0 : rp[sel_lvl] + 1'b1;
          cnt_n[sel_lvl] = cnt[sel_lvl] - 1'b1;
          served_n = served + 32'd1;
          win_n    = w9[7:0];
          last_n   = seconds_q;
          row_we   = 1'b1;
        end
      end
      default: begin
        res_d.status = spsq_pkg::STATUS_OK;
      end
    endcase
    if (svalid) begin
      res_d.window    = win_n;
      res_d.processed = served_n;
    end
    for (int k = 0; k < NUM_LEVELS; k++) begin
      row_wr[k*LVW +: PW]          = wp_n[k];
      row_wr[k*LVW + PW +: PW]     = rp_n[k];
      row_wr[k*LVW + 2*PW +: CW]   = cnt_n[k];
    end
    row_wr[LB +: 8]       = win_n;
    row_wr[LB + 8 +: 32]  = last_n;
    row_wr[LB + 40 +: 32] = served_n;
  end

  // per-stream state rows
  spsq_state_mem #(
    .DEPTH     (NUM_STREAMS),
    .RW        (RW),
    .ROW_RESET (ROW_RESET)
  ) u_state_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    ((state_q == ST_EXEC) && row_we),
    .waddr_i (sidx),
    .wdata_i (row_wr),
    .re_i    (in_fire && in_stream_ok),
    .raddr_i (SW'(in_data_i.stream)),
    .rdata_o (row_rd)
  );

  // handle storage
  spsq_handle_mem #(
    .AW (HAW)
  ) u_handle_mem (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_EXEC) && (cur_q.cmd == spsq_pkg::CMD_SUBMIT) && sub_ok),
    .waddr_i ({sidx, sub_lvl, wp[sub_lvl]}),
    .wdata_i (cur_q.handle),
    .re_i    ((state_q == ST_EXEC) && (cur_q.cmd == spsq_pkg::CMD_SERVE) && svalid && srv_hit),
    .raddr_i ({sidx, sel_lvl, rp[sel_lvl]}),
    .rdata_o (hm_rdata)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_window_q <= spsq_pkg::MaxWindowReset;
    end else if (cfg_we_i) begin
      max_window_q <= cfg_wdata_i;
    end
  end

  // sequencer, seconds count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      seconds_q   <= '0;
    end else begin
      // result taken, unless the next one is loaded in its place
      if (out_valid_q && out_ready_i && (state_q != ST_RESP)) begin
        out_valid_q <= 1'b0;
      end
      if (in_fire) begin
        cur_q <= in_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_q   <= res_d;
          state_q <= ST_RESP;
          if (cur_q.cmd == spsq_pkg::CMD_TICK) begin
            seconds_q <= seconds_q + 32'd1;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q               <= 1'b1;
            out_q.status              <= res_q.status;
            out_q.served_handle       <= res_q.hit ? hm_rdata : 16'd0;
            out_q.served_priority     <= res_q.served_priority;
            out_q.window              <= res_q.window;
            out_q.processed           <= res_q.processed;
            state_q                   <= in_fire ? ST_EXEC : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/spsq_handle_mem.sv */
// handle storage for all ring fifos, one write and one registered read port
module spsq_handle_mem #(
  parameter int AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem_q [2**AW];
  logic [15:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/spsq_state_mem.sv */
// per-stream state rows with valid bits, unwritten rows read as reset value
module spsq_state_mem #(
  parameter int              DEPTH     = 16,
  parameter int              RW        = 8,
  parameter logic [RW-1:0]   ROW_RESET = '0,
  localparam int             AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [RW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [RW-1:0] rdata_o
);

  logic [RW-1:0]    mem_q [DEPTH];
  logic [RW-1:0]    rdata_q;
  logic [DEPTH-1:0] row_valid_q;
  logic             rd_valid_q;

  // row storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        row_valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= row_valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rdata_q : ROW_RESET;

endmodule

/* rtl/spsq_checker.sv */
// port-level checks for the strict priority stream queues, bound to the top
module spsq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input spsq_pkg::out_item_t out_data_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted in back-to-back cycles");

  // an empty serve returns no handle
  a_empty_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == spsq_pkg::STATUS_EMPTY) |->
      (out_data_o.served_handle == 16'd0) && (out_data_o.served_priority == 2'd0))
    else $error("empty serve carries a handle");

  // a refused submit returns no handle
  a_full_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == spsq_pkg::STATUS_FULL) |->
      (out_data_o.served_handle == 16'd0))
    else $error("full submit carries a handle");

endmodule

bind strict_priority_stream_queues_top spsq_checker u_spsq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* bench/strict_priority_stream_queues_top_test.sv */
// self-checking testbench for the strict priority stream queues
module strict_priority_stream_queues_top_test;
  import spsq_pkg::*;

  localparam int STREAMS = NumStreamsDef;
  localparam int LEVELS = NumLevelsDef;
  localparam int DEPTH = QueueDepthDef;
  localparam int NUM_FIFOS = STREAMS * LEVELS;
  localparam int DIR_ROWS = 24;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 360;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int REPORT_LIMIT = 10;

  // unused command code: no queue change and no tick
  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_THREE_OF_FOUR,
    RX_COIN,
    RX_LONG_STALL
  } rx_mode_e;

  // one directed row: command, and the result when it is obvious
  typedef struct packed {
    in_item_t  cmd_in;
    logic      known;
    out_item_t typed;
  } dir_row_t;

  localparam out_item_t UNTYPED = '0;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_item_t  out_data_o;

  // travels with each transaction so the monitor knows a typed result
  logic      row_known;
  out_item_t row_typed;

  // scheduler shadow state
  logic [15:0] fifo_mem [NUM_FIFOS][DEPTH];
  int          fifo_wr [NUM_FIFOS];
  int          fifo_rd [NUM_FIFOS];
  int          fifo_fill [NUM_FIFOS];
  logic [7:0]  stream_win [STREAMS];
  logic [31:0] last_adj [STREAMS];
  logic [31:0] served_cnt [STREAMS];
  logic [31:0] sec_now;
  logic [7:0]  max_win_cfg;

  out_item_t cmd_results_q [$];
  out_item_t predicted;
  out_item_t want;
  dir_row_t  dir_rows [DIR_ROWS];

  int fail_count = 0;
  int result_count = 0;
  int item_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int full_seen = 0;
  int empty_seen = 0;

  logic [5:0] rx_tick = '0;
  rx_mode_e   rx_mode = RX_ALWAYS;

  strict_priority_stream_queues_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // applies one command to the shadow state and returns its result
  function automatic out_item_t apply_command(input in_item_t c);
    out_item_t   r;
    int          s;
    int          q;
    int          lvl;
    int          w;
    int          top;
    logic [31:0] elapsed;
    r = '0;
    s = int'(c.stream);
    case (c.cmd)
      CMD_SUBMIT: begin
        q = s * LEVELS + int'(c.priority_req);
        r.status = STATUS_FULL;
        if (fifo_fill[q] < DEPTH) begin
          fifo_mem[q][fifo_wr[q]] = c.handle;
          fifo_wr[q] = (fifo_wr[q] + 1) % DEPTH;
          fifo_fill[q]++;
          r.status = STATUS_OK;
        end
      end
      CMD_SERVE: begin
        r.status = STATUS_EMPTY;
        // highest non-empty level wins
        for (lvl = LEVELS - 1; lvl >= 0 && r.status == STATUS_EMPTY; lvl--) begin
          q = s * LEVELS + lvl;
          if (fifo_fill[q] > 0) begin
            r.status = STATUS_OK;
            r.served_handle = fifo_mem[q][fifo_rd[q]];
            r.served_priority = 2'(lvl);
            fifo_rd[q] = (fifo_rd[q] + 1) % DEPTH;
            fifo_fill[q]--;
            served_cnt[s]++;
            // grow by one after more than a second, clamp to 1..max_window
            top = (max_win_cfg == 8'd0) ? 1 : int'(max_win_cfg);
            w = int'(stream_win[s]);
            elapsed = sec_now - last_adj[s];
            if (elapsed > 32'd1) w++;
            if (w > top) begin
              w = top;
            end else if (w < 1) begin
              w = 1;
            end
            stream_win[s] = 8'(w);
            last_adj[s] = sec_now;
          end
        end
      end
      CMD_TICK: sec_now++;
      default: ;
    endcase
    r.window = stream_win[s];
    r.processed = served_cnt[s];
    return r;
  endfunction

  // receiver stalls on a pattern that changes each time rx_tick wraps
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == '0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_ALWAYS:        out_ready_i <= 1'b1;
      RX_THREE_OF_FOUR: out_ready_i <= (rx_tick[1:0] != 2'd0);
      RX_COIN:          out_ready_i <= 1'($urandom_range(0, 1));
      default:          out_ready_i <= (rx_tick[3:0] > 4'd10);
    endcase
  end

  // monitor: predict on each command transaction, check each result transaction
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predicted = apply_command(in_data_i);
      cmd_results_q.push_back(row_known ? row_typed : predicted);
    end
    if (out_valid_o && out_ready_i) begin
      result_count++;
      if (cmd_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("result %0d arrived with no command waiting: %h", result_count, out_data_o);
      end else begin
        want = cmd_results_q.pop_front();
        if (want.status == STATUS_FULL) full_seen++;
        if (want.status == STATUS_EMPTY) empty_seen++;
        if (out_data_o.status !== want.status ||
            out_data_o.served_handle !== want.served_handle ||
            out_data_o.served_priority !== want.served_priority ||
            out_data_o.window !== want.window ||
            out_data_o.processed !== want.processed) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("result %0d expected status %0d handle %h level %0d window %0d count %0d",
                     result_count, want.status, want.served_handle, want.served_priority,
                     want.window, want.processed);
            $display("result %0d actual   status %0d handle %h level %0d window %0d count %0d",
                     result_count, out_data_o.status, out_data_o.served_handle,
                     out_data_o.served_priority, out_data_o.window, out_data_o.processed);
          end
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: %0d cycles without a transaction", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // sends one command, with bursts and random gaps between them
  task automatic drive_cmd(input in_item_t it, input logic known, input out_item_t typed);
    int gap;
    if (burst_left == 0) begin
      // no pause about half the time
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    row_known <= known;
    row_typed <= typed;
    if (it.cmd != CMD_NONE) item_count++;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // waits until every issued command has returned its result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cmd_results_q.size() != 0) @(posedge clk_i);
  endtask

  // max_window is written only while the block is idle
  task automatic write_max_window(input logic [7:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    max_win_cfg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [7:0] cfg_plan [PHASES];
    in_item_t   it;
    int         phase;
    int         kind;
    int         n;
    int         r;
    int         target;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    row_known <= 1'b0;
    row_typed <= UNTYPED;

    // shadow state after reset
    for (r = 0; r < NUM_FIFOS; r++) begin
      fifo_wr[r] = 0;
      fifo_rd[r] = 0;
      fifo_fill[r] = 0;
    end
    for (r = 0; r < STREAMS; r++) begin
      stream_win[r] = WindowReset;
      last_adj[r] = '0;
      served_cnt[r] = '0;
    end
    sec_now = '0;
    max_win_cfg = MaxWindowReset;

    // directed table: extremes, every command, tick and no-op reporting
    dir_rows[0]  = {CMD_SERVE, 4'd0, 2'd0, 16'h0000,
                    1'b1, STATUS_EMPTY, 16'h0000, 2'd0, 8'd64, 32'd0};
    dir_rows[1]  = {CMD_TICK, 4'd15, 2'd3, 16'hffff,
                    1'b1, STATUS_OK, 16'h0000, 2'd0, 8'd64, 32'd0};
    dir_rows[2]  = {CMD_NONE, 4'd5, 2'd3, 16'hffff,
                    1'b1, STATUS_OK, 16'h0000, 2'd0, 8'd64, 32'd0};
    dir_rows[3]  = {CMD_SUBMIT, 4'd0, 2'd0, 16'h0000,
                    1'b1, STATUS_OK, 16'h0000, 2'd0, 8'd64, 32'd0};
    dir_rows[4]  = {CMD_SUBMIT, 4'd0, 2'd3, 16'hffff,
                    1'b1, STATUS_OK, 16'h0000, 2'd0, 8'd64, 32'd0};
    dir_rows[5]  = {CMD_SUBMIT, 4'd0, 2'd1, 16'h1234,
                    1'b1, STATUS_OK, 16'h0000, 2'd0, 8'd64, 32'd0};
    dir_rows[6]  = {CMD_SERVE, 4'd0, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[7]  = {CMD_SERVE, 4'd0, 2'd2, 16'h5555, 1'b0, UNTYPED};
    dir_rows[8]  = {CMD_SERVE, 4'd0, 2'd1, 16'haaaa, 1'b0, UNTYPED};
    // stream drained: empty, count stays at three
    dir_rows[9]  = {CMD_SERVE, 4'd0, 2'd3, 16'hffff,
                    1'b1, STATUS_EMPTY, 16'h0000, 2'd0, 8'd64, 32'd3};
    dir_rows[10] = {CMD_TICK, 4'd0, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[11] = {CMD_TICK, 4'd15, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[12] = {CMD_SUBMIT, 4'd15, 2'd2, 16'ha5a5, 1'b0, UNTYPED};
    dir_rows[13] = {CMD_SUBMIT, 4'd15, 2'd3, 16'h8001, 1'b0, UNTYPED};
    dir_rows[14] = {CMD_SERVE, 4'd15, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[15] = {CMD_SERVE, 4'd15, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[16] = {CMD_SUBMIT, 4'd7, 2'd1, 16'h7fff, 1'b0, UNTYPED};
    dir_rows[17] = {CMD_SUBMIT, 4'd8, 2'd2, 16'h0001, 1'b0, UNTYPED};
    dir_rows[18] = {CMD_SERVE, 4'd7, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[19] = {CMD_SERVE, 4'd8, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[20] = {CMD_SERVE, 4'd9, 2'd0, 16'h0000,
                    1'b1, STATUS_EMPTY, 16'h0000, 2'd0, 8'd64, 32'd0};
    dir_rows[21] = {CMD_NONE, 4'd10, 2'd0, 16'h0000, 1'b0, UNTYPED};
    dir_rows[22] = {CMD_SUBMIT, 4'd3, 2'd3, 16'hfffe, 1'b0, UNTYPED};
    dir_rows[23] = {CMD_SERVE, 4'd3, 2'd0, 16'h0000, 1'b0, UNTYPED};

    // window limits: top, floor, zero acting as one, random, back to default
    cfg_plan[0] = 8'd255;
    cfg_plan[1] = 8'd1;
    cfg_plan[2] = 8'd0;
    cfg_plan[3] = 8'($urandom_range(2, 254));
    cfg_plan[4] = 8'd64;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < DIR_ROWS; r++)
      drive_cmd(dir_rows[r].cmd_in, dir_rows[r].known, dir_rows[r].typed);

    // random phases, one window limit each
    for (phase = 0; phase < PHASES; phase++) begin
      write_max_window(cfg_plan[phase]);
      target = item_count + PHASE_ITEMS;
      while (item_count < target) begin
        kind = $urandom_range(0, 9);
        // low streams get most traffic so their queues run deep
        it.stream = ($urandom_range(0, 1) == 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        it.priority_req = 2'($urandom);
        it.handle = 16'($urandom);
        if (kind == 0) begin
          // fill one queue past its depth
          it.cmd = CMD_SUBMIT;
          n = DEPTH + $urandom_range(1, 2);
          repeat (n) begin
            it.handle = 16'($urandom);
            drive_cmd(it, 1'b0, UNTYPED);
          end
        end else if (kind <= 3) begin
          // drain a stream, often past empty
          it.cmd = CMD_SERVE;
          repeat ($urandom_range(1, 20)) drive_cmd(it, 1'b0, UNTYPED);
        end else if (kind == 4) begin
          // let seconds pass so windows can grow
          it.cmd = CMD_TICK;
          repeat ($urandom_range(1, 4)) begin
            it.stream = 4'($urandom);
            drive_cmd(it, 1'b0, UNTYPED);
          end
        end else begin
          n = $urandom_range(0, 19);
          it.cmd = (n < 8) ? CMD_SUBMIT : (n < 16) ? CMD_SERVE : (n < 19) ? CMD_TICK : CMD_NONE;
          drive_cmd(it, 1'b0, UNTYPED);
        end
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("%0d commands, %0d results checked under %0d window limits",
             item_count, result_count, PHASES + 1);
    $display("%0d full and %0d empty answers seen, %0d failures",
             full_seen, empty_seen, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
